/* rtl/core/first_fit_heap_allocator_top_assert.svh */
// ---------------------------------------------------------------------------
// First-fit heap allocator assertion macros
// Concurrent check macros for the allocator top level; empty under SYNTH.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication on clock, disabled in reset
`define FFHA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ffha: same-cycle check failed");
// next-cycle implication on clock, disabled in reset
`define FFHA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ffha: next-cycle check failed");
`else
`define FFHA_ASSERT_IMPL(label, ante, cons)
`define FFHA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/core/ffha_pkg.sv */
// ---------------------------------------------------------------------------
// First-fit heap allocator package
// Shared types, codes and constants of the allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;

   localparam int ADDR_W = 32;
   localparam int REC_W  = 2 * ADDR_W;   // {start, length}
   localparam int RIU_W  = 9;

   // size rounding granule mask (16 bytes)
   localparam logic [ADDR_W:0] GRAN_MASK = 33'hf;

   // operation codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_TABLE_BASE   = 2'd0;
   localparam logic [1:0] CSR_ARENA_START  = 2'd1;
   localparam logic [1:0] CSR_HEAP_END     = 2'd2;
   localparam logic [1:0] CSR_RECORDS_USED = 2'd3;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_NO_RECORD = 3'd1,
      STS_EXHAUSTED = 3'd2,
      STS_BAD_FREE  = 3'd3,
      STS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_RESP
   } state_type;

endpackage

/* rtl/core/ffha_ram.sv */
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module ffha_ram #(
   parameter  int WIDTH = 64,
   parameter  int DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/first_fit_heap_allocator_top.sv */
// ---------------------------------------------------------------------------
// First-fit heap allocator
// Allocate/free over a table of {start, length} records held in one RAM.
// ---------------------------------------------------------------------------
// After reset the record RAM is swept to zero slot by slot; requests
// wait, configuration writes are taken. Every record visit goes through the
// single read port of the record RAM, one slot per cycle with registered
// read data, over n = min(records_in_use, RECORDS) slots. A free takes at
// most one pass from accept to response. An allocate takes one full pass
// plus, for every time its candidate is moved past an overlapping record,
// the partial pass up to that record and a fit check, so its time depends
// on the table contents. One request is worked on at a time; the response
// register lets the next request in while the last response waits to be
// taken.
`include "first_fit_heap_allocator_top_assert.svh"

module first_fit_heap_allocator_top
   import ffha_pkg::*;
#(
   parameter int RECORDS = 256
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [ADDR_W-1:0] req_request_size,
   input  logic [ADDR_W-1:0] req_block_address,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_granted_address,
   output logic [2:0]        rsp_status,
   // configuration channel
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [ADDR_W-1:0] csr_data
);

   localparam int AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
   localparam int IW = $clog2(RECORDS + 1);

   // configuration registers
   logic [ADDR_W-1:0] csr_table_base_ff;
   logic [ADDR_W-1:0] csr_arena_start_ff;
   logic [ADDR_W-1:0] csr_heap_end_ff;
   logic [RIU_W-1:0]  csr_records_used_ff;

   // control
   state_type         state_ff, state_in;
   logic [IW-1:0]     issue_idx_ff, issue_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic              free_found_ff, free_found_in;
   logic [AW-1:0]     free_idx_ff, free_idx_in;

   // request context
   logic              op_ff, op_in;
   logic [ADDR_W:0]   len_ff, len_in;
   logic [ADDR_W:0]   cand_ff, cand_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   // pending result
   status_type        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [AW-1:0]     wr_idx_ff, wr_idx_in;
   logic [REC_W-1:0]  wr_data_ff, wr_data_in;

   // response register
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_granted_ff;
   status_type        rsp_status_ff;
   logic              rsp_load;
   logic              out_free;

   // record RAM ports
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [REC_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [REC_W-1:0]  ram_rd_data;

   // datapath
   logic [IW-1:0]     slot_n;
   logic [ADDR_W-1:0] rec_start;
   logic [ADDR_W-1:0] rec_len;
   logic              rec_live;
   logic [ADDR_W:0]   rec_end;
   logic [ADDR_W+1:0] cand_end;
   logic [ADDR_W+1:0] heap_end_x;
   logic              overlap;
   logic              scan_hit;
   logic [ADDR_W:0]   size_round;

   ffha_ram #(
      .WIDTH (REC_W),
      .DEPTH (RECORDS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_table_base_ff   <= '0;
         csr_arena_start_ff  <= '0;
         csr_heap_end_ff     <= '0;
         csr_records_used_ff <= RIU_W'(256);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TABLE_BASE:   csr_table_base_ff   <= csr_data;
            CSR_ARENA_START:  csr_arena_start_ff  <= csr_data;
            CSR_HEAP_END:     csr_heap_end_ff     <= csr_data;
            CSR_RECORDS_USED: csr_records_used_ff <= csr_data[RIU_W-1:0];
            default: ;
         endcase
      end
   end

   // scanned slot count: min(records_in_use, RECORDS)
   always_comb begin
      if (32'(csr_records_used_ff) < 32'(RECORDS)) begin
         slot_n = IW'(csr_records_used_ff);
      end else begin
         slot_n = IW'(RECORDS);
      end
   end

   // record compare against the candidate, sums kept wide so they never wrap
   assign rec_start  = ram_rd_data[REC_W-1:ADDR_W];
   assign rec_len    = ram_rd_data[ADDR_W-1:0];
   assign rec_live   = (rec_len != '0);
   assign rec_end    = {1'b0, rec_start} + {1'b0, rec_len};
   assign cand_end   = {1'b0, cand_ff} + {1'b0, len_ff};
   assign heap_end_x = {2'b00, csr_heap_end_ff};
   assign size_round = ({1'b0, req_request_size} + (ADDR_W+1)'(15)) & ~GRAN_MASK;

   always_comb begin
      if ({1'b0, rec_start} == cand_ff) begin
         overlap = 1'b1;
      end else if ({1'b0, rec_start} < cand_ff) begin
         overlap = (cand_ff < rec_end);
      end else begin
         overlap = ({2'b00, rec_start} < cand_end);
      end
   end

   always_comb begin
      if (op_ff == FUNC_ALLOC) begin
         scan_hit = rd_vld_ff && rec_live && overlap;
      end else begin
         scan_hit = rd_vld_ff && rec_live && (rec_start == addr_ff);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // sequencer: next state, RAM control and context updates
   always_comb begin
      state_in      = state_ff;
      issue_idx_in  = issue_idx_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = issue_idx_ff[AW-1:0];
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      op_in         = op_ff;
      len_in        = len_ff;
      cand_in       = cand_ff;
      addr_in       = addr_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      wr_pend_in    = wr_pend_ff;
      wr_idx_in     = wr_idx_ff;
      wr_data_in    = wr_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wr_idx_ff;
      ram_wr_data   = wr_data_ff;
      ram_rd_en     = 1'b0;
      rsp_load      = 1'b0;

      case (state_ff)
         // zero sweep of the record RAM after reset
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = issue_idx_ff[AW-1:0];
            ram_wr_data = '0;
            if (issue_idx_ff == IW'(RECORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               issue_idx_in = issue_idx_ff + IW'(1);
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_func;
               len_in        = size_round;
               cand_in       = {1'b0, csr_arena_start_ff};
               addr_in       = req_block_address;
               issue_idx_in  = '0;
               free_found_in = 1'b0;
               if (req_func == FUNC_FREE &&
                   (req_block_address < csr_table_base_ff ||
                    req_block_address > csr_heap_end_ff)) begin
                  res_status_in = STS_BAD_FREE;
                  res_addr_in   = '0;
                  wr_pend_in    = 1'b0;
                  state_in      = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         // stream slots through the read port, evaluate each in the cycle after its read
         ST_SCAN: begin
            if (scan_hit) begin
               if (op_ff == FUNC_ALLOC) begin
                  cand_in      = rec_end;
                  issue_idx_in = '0;
                  state_in     = ST_CHECK;
               end else begin
                  res_status_in = STS_OK;
                  res_addr_in   = '0;
                  wr_pend_in    = 1'b1;
                  wr_idx_in     = rd_idx_ff;
                  wr_data_in    = '0;
                  state_in      = ST_RESP;
               end
            end else begin
               // first free slot of this pass
               if (op_ff == FUNC_ALLOC && rd_vld_ff && !rec_live && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
               if (issue_idx_ff < slot_n) begin
                  ram_rd_en    = 1'b1;
                  rd_vld_in    = 1'b1;
                  issue_idx_in = issue_idx_ff + IW'(1);
               end else if (!rd_vld_ff) begin
                  // pass finished with no hit
                  wr_pend_in = 1'b0;
                  res_addr_in = '0;
                  state_in   = ST_RESP;
                  if (op_ff == FUNC_FREE) begin
                     res_status_in = STS_NOT_FOUND;
                  end else if (!free_found_ff) begin
                     res_status_in = STS_NO_RECORD;
                  end else if (heap_end_x <= cand_end) begin
                     res_status_in = STS_EXHAUSTED;
                  end else begin
                     res_status_in = STS_OK;
                     res_addr_in   = cand_ff[ADDR_W-1:0];
                     wr_pend_in    = 1'b1;
                     wr_idx_in     = free_idx_ff;
                     wr_data_in    = {cand_ff[ADDR_W-1:0], len_ff[ADDR_W-1:0]};
                  end
               end
            end
         end

         // candidate moved: check it still fits, then rescan
         ST_CHECK: begin
            if (cand_end >= heap_end_x) begin
               res_status_in = STS_EXHAUSTED;
               res_addr_in   = '0;
               wr_pend_in    = 1'b0;
               state_in      = ST_RESP;
            end else begin
               free_found_in = 1'b0;
               issue_idx_in  = '0;
               state_in      = ST_SCAN;
            end
         end

         // commit record write and hand result to the response register
         ST_RESP: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               ram_wr_en = wr_pend_ff;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         issue_idx_ff  <= '0;
         rd_vld_ff     <= 1'b0;
         free_found_ff <= 1'b0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_idx_ff  <= issue_idx_in;
         rd_vld_ff     <= rd_vld_in;
         free_found_ff <= free_found_in;
         wr_pend_ff    <= wr_pend_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      free_idx_ff   <= free_idx_in;
      op_ff         <= op_in;
      len_ff        <= len_in;
      cand_ff       <= cand_in;
      addr_ff       <= addr_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      wr_idx_ff     <= wr_idx_in;
      wr_data_ff    <= wr_data_in;
      if (rsp_load) begin
         rsp_granted_ff <= res_addr_ff;
         rsp_status_ff  <= res_status_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_status          = rsp_status_ff;

   // checks
   `FFHA_ASSERT_IMPL(a_rd_only_in_scan, rd_vld_ff, state_ff == ST_SCAN)
   `FFHA_ASSERT_IMPL(a_issue_bound, state_ff == ST_SCAN, issue_idx_ff <= slot_n)
   `FFHA_ASSERT_IMPL(a_grant_zero_on_error, rsp_valid_ff && (rsp_status_ff != STS_OK), rsp_granted_ff == '0)
   `FFHA_ASSERT_NEXT(a_resp_handoff, (state_ff == ST_RESP) && out_free, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule
